FILE: rtl/ssg_pkg.sv
`default_nettype none

package ssg_pkg;

  localparam int SineEntries = 181;
  localparam int QueueDepth  = 2;
  localparam logic [63:0] PiQ30 = 64'd3373259426;

  typedef struct packed {
    logic [7:0] ir_distance;
    logic [9:0] sonar_distance;
    logic       sweep_start;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  object_number;
    logic [9:0]  object_distance;
    logic [12:0] object_width;
    logic [7:0]  object_center;
  } out_word_t;

  typedef struct packed {
    logic [7:0] ir_low_limit;
    logic [7:0] ir_high_limit;
    logic [7:0] agree_limit;
    logic [3:0] confirm_count;
  } cfg_t;

  // closed object handed from front to back
  typedef struct packed {
    logic [6:0] number;
    logic [9:0] distance;
    logic [7:0] run_length;
    logic [7:0] center;
  } job_t;

  typedef enum logic [1:0] {
    RegIrLow   = 2'd0,
    RegIrHigh  = 2'd1,
    RegAgree   = 2'd2,
    RegConfirm = 2'd3
  } cfg_reg_e;

  typedef logic [15:0] sine_tab_t [SineEntries];

  // sin(h/2 deg) in Q1.15, Taylor series in Q2.30, evaluated at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    for (int h = 0; h < SineEntries; h++) begin
      x    = (64'(h) * PiQ30) / 64'd360;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      tab[h] = r[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine_tab();

endpackage

`default_nettype wire

FILE: rtl/ssg_front.sv
`default_nettype none

module ssg_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  ssg_pkg::cfg_t      cfg_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  ssg_pkg::in_word_t  in_word_i,
  input  wire                q_full_i,
  output logic               q_push_o,
  output ssg_pkg::job_t      q_job_o
);
  import ssg_pkg::*;

  logic [7:0] angle_q, angle_d;
  logic [7:0] hit_count_q, hit_count_d;
  logic       opened_q, opened_d;
  logic       in_object_q, in_object_d;
  logic [7:0] run_length_q, run_length_d;
  logic [9:0] latched_q, latched_d;
  logic [6:0] count_q, count_d;
  logic       accept;
  logic       close;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept && close;

  always_comb begin
    logic [7:0]  ang;
    logic [7:0]  hc;
    logic        op;
    logic        io;
    logic [7:0]  rl;
    logic [9:0]  ld;
    logic [6:0]  cnt;
    logic [10:0] ir_ext;
    logic [10:0] so_ext;
    logic [10:0] diff;
    logic        in_window;
    logic        out_window;
    logic        hit;
    logic [7:0]  half;

    ang = in_word_i.sweep_start ? '0 : angle_q;
    hc  = in_word_i.sweep_start ? '0 : hit_count_q;
    op  = in_word_i.sweep_start ? 1'b0 : opened_q;
    io  = in_word_i.sweep_start ? 1'b0 : in_object_q;
    rl  = in_word_i.sweep_start ? '0 : run_length_q;
    ld  = in_word_i.sweep_start ? '0 : latched_q;
    cnt = in_word_i.sweep_start ? '0 : count_q;

    ir_ext = {3'b000, in_word_i.ir_distance};
    so_ext = {1'b0, in_word_i.sonar_distance};
    diff   = (ir_ext > so_ext) ? (ir_ext - so_ext) : (so_ext - ir_ext);

    in_window  = (in_word_i.ir_distance > cfg_i.ir_low_limit) &&
                 (in_word_i.ir_distance < cfg_i.ir_high_limit);
    out_window = (in_word_i.ir_distance < cfg_i.ir_low_limit) ||
                 (in_word_i.ir_distance > cfg_i.ir_high_limit);
    hit = in_window && (diff < {3'b000, cfg_i.agree_limit});

    if (hit) begin
      if (hc != 8'hFF) begin
        hc = hc + 8'd1;
      end
      if ((hc > {4'h0, cfg_i.confirm_count}) && !op) begin
        rl = (rl > 8'd253) ? 8'hFF : rl + 8'd2;
        op = 1'b1;
        ld = in_word_i.sonar_distance;
      end
      if (op) begin
        if (rl != 8'hFF) begin
          rl = rl + 8'd1;
        end
        io = 1'b1;
      end
    end

    close = io && out_window && (diff > {3'b000, cfg_i.agree_limit});

    half = {1'b0, rl[7:1]};
    q_job_o.number     = cnt;
    q_job_o.distance   = ld;
    q_job_o.run_length = rl;
    q_job_o.center     = (ang >= half) ? (ang - half) : '0;

    if (close) begin
      io  = 1'b0;
      rl  = '0;
      hc  = '0;
      op  = 1'b0;
      cnt = cnt + 7'd1;
    end

    angle_d          = (ang != 8'hFF) ? ang + 8'd1 : ang;
    hit_count_d      = hc;
    opened_d         = op;
    in_object_d      = io;
    run_length_d     = rl;
    latched_d        = ld;
    count_d          = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q      <= '0;
      hit_count_q  <= '0;
      opened_q     <= 1'b0;
      in_object_q  <= 1'b0;
      run_length_q <= '0;
      latched_q    <= '0;
      count_q      <= '0;
    end else if (accept) begin
      angle_q      <= angle_d;
      hit_count_q  <= hit_count_d;
      opened_q     <= opened_d;
      in_object_q  <= in_object_d;
      run_length_q <= run_length_d;
      latched_q    <= latched_d;
      count_q      <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssg_queue.sv
`default_nettype none

module ssg_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  ssg_pkg::job_t   push_job_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            valid_o,
  output ssg_pkg::job_t   pop_job_o
);
  import ssg_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  job_t                  slot_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]         fill_q, fill_d;

  assign full_o    = (fill_q == (PtrW + 1)'(QueueDepth));
  assign valid_o   = (fill_q != '0);
  assign pop_job_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    fill_d = fill_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssg_back.sv
`default_nettype none

module ssg_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_valid_i,
  input  ssg_pkg::job_t       q_job_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ssg_pkg::out_word_t  out_word_o
);
  import ssg_pkg::*;

  logic        s1_valid_q;
  job_t        s1_job_q;
  logic [15:0] s1_sine_q;
  logic        s2_valid_q;
  job_t        s2_job_q;
  logic [25:0] s2_prod_q;
  logic        out_valid_q;
  out_word_t   out_word_q;

  logic        out_adv;
  logic        s2_adv;
  logic        s1_adv;
  logic [8:0]  half_idx;
  logic [25:0] rounded;

  assign out_adv = !out_valid_q || !out_stall_i;
  assign s2_adv  = !s2_valid_q || out_adv;
  assign s1_adv  = !s1_valid_q || s2_adv;
  assign q_pop_o = q_valid_i && s1_adv;

  // sin(x) = sin(180 - x) beyond the quarter turn
  assign half_idx = (q_job_i.run_length > 8'd180) ? (9'd360 - {1'b0, q_job_i.run_length})
                                                  : {1'b0, q_job_i.run_length};
  assign rounded  = s2_prod_q + 26'd2048;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv && q_valid_i) begin
      s1_job_q  <= q_job_i;
      s1_sine_q <= SineTab[half_idx[7:0]];
    end
    if (s2_adv && s1_valid_q) begin
      s2_job_q  <= s1_job_q;
      s2_prod_q <= {16'h0000, s1_job_q.distance} * {10'h000, s1_sine_q};
    end
    if (out_adv && s2_valid_q) begin
      out_word_q.object_number   <= s2_job_q.number;
      out_word_q.object_distance <= s2_job_q.distance;
      out_word_q.object_width    <= rounded[24:12];
      out_word_q.object_center   <= s2_job_q.center;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sweep_object_segmenter.sv
// A word that closes an object is queued as a job, then passes the back end to the output.
// Throughput: one input word per cycle; the front stalls only while the 2-entry job queue is full.
// Back end: sine lookup, 10x16 multiply and rounding, one registered stage each.
// Reset (async, active low): all tracking state zero, limits 10/80/15/2, pipeline empty.
`default_nettype none

module sweep_object_segmenter (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  ssg_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ssg_pkg::out_word_t  out_word_o
);
  import ssg_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     cfg_wr;
  logic     q_full;
  logic     q_push;
  job_t     q_push_job;
  logic     q_pop;
  logic     q_valid;
  job_t     q_pop_job;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      RegIrLow:   prdata = {24'h0, cfg_q.ir_low_limit};
      RegIrHigh:  prdata = {24'h0, cfg_q.ir_high_limit};
      RegAgree:   prdata = {24'h0, cfg_q.agree_limit};
      RegConfirm: prdata = {28'h0, cfg_q.confirm_count};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ir_low_limit  <= 8'd10;
      cfg_q.ir_high_limit <= 8'd80;
      cfg_q.agree_limit   <= 8'd15;
      cfg_q.confirm_count <= 4'd2;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegIrLow:   cfg_q.ir_low_limit  <= pwdata[7:0];
        RegIrHigh:  cfg_q.ir_high_limit <= pwdata[7:0];
        RegAgree:   cfg_q.agree_limit   <= pwdata[7:0];
        RegConfirm: cfg_q.confirm_count <= pwdata[3:0];
        default:    ;
      endcase
    end
  end

  ssg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_push_job)
  );

  ssg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_job_o  (q_pop_job)
  );

  ssg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

FILE: bench/tb_sweep_object_segmenter.sv
`default_nettype none

module tb_sweep_object_segmenter;
  timeunit 1ns;
  timeprecision 1ps;

  import ssg_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles = 400;
  localparam logic [63:0] PiQ30Tb = 64'd3373259426;

  typedef enum logic [1:0] {
    ByModel     = 2'd0,
    NoObject    = 2'd1,
    TypedObject = 2'd2
  } row_kind_e;

  typedef struct packed {
    logic [7:0] ir;
    logic [9:0] sonar;
    logic       start;
    row_kind_e  kind;
    out_word_t  obj;
  } probe_row_t;

  // reset limits 10/80/15/2
  localparam probe_row_t ProbeRows [20] = '{
    '{8'd0,   10'd0,    1'b1, NoObject,    '0},
    '{8'd255, 10'd1023, 1'b0, NoObject,    '0},
    '{8'd11,  10'd0,    1'b1, NoObject,    '0},
    '{8'd11,  10'd0,    1'b0, NoObject,    '0},
    '{8'd14,  10'd0,    1'b0, NoObject,    '0},
    '{8'd200, 10'd0,    1'b0, TypedObject, '{7'd0, 10'd0, 13'd0, 8'd2}},
    '{8'd79,  10'd93,   1'b0, ByModel,     '0},
    '{8'd79,  10'd65,   1'b0, ByModel,     '0},
    '{8'd50,  10'd50,   1'b0, ByModel,     '0},
    '{8'd50,  10'd50,   1'b0, ByModel,     '0},
    '{8'd80,  10'd80,   1'b0, ByModel,     '0},
    '{8'd10,  10'd10,   1'b0, ByModel,     '0},
    '{8'd9,   10'd24,   1'b0, ByModel,     '0},
    '{8'd9,   10'd25,   1'b0, ByModel,     '0},
    '{8'd40,  10'd40,   1'b1, ByModel,     '0},
    '{8'd40,  10'd40,   1'b0, ByModel,     '0},
    '{8'd40,  10'd40,   1'b0, ByModel,     '0},
    '{8'd40,  10'd40,   1'b1, NoObject,    '0},
    '{8'd0,   10'd100,  1'b0, NoObject,    '0},
    '{8'd255, 10'd0,    1'b0, ByModel,     '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;

  sweep_object_segmenter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // tracker state and limits
  cfg_t       limits = '{8'd10, 8'd80, 8'd15, 4'd2};
  logic [7:0] sweep_angle = '0;
  logic [7:0] hit_run = '0;
  logic [7:0] run_deg = '0;
  bit         armed = 1'b0;
  bit         tracking = 1'b0;
  logic [9:0] held_distance = '0;
  logic [6:0] closed_count = '0;

  out_word_t  expected_objects [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         words_sent = 0;
  bit         sweep_pending = 1'b0;
  bit         hold_request = 1'b0;
  bit         hold_done = 1'b0;

  function automatic int half_angle_sine(int h);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] r;
    x = (64'(h) * PiQ30Tb) / 64'd360;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    r = (acc + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return int'(r);
  endfunction

  function automatic void clear_tracking();
    sweep_angle = '0;
    hit_run = '0;
    run_deg = '0;
    armed = 1'b0;
    tracking = 1'b0;
    held_distance = '0;
    closed_count = '0;
  endfunction

  function automatic bit track_sample(input in_word_t w, output out_word_t obj);
    int ir;
    int sonar;
    int diff;
    int h;
    int half;
    int width;
    bit hit;
    bit emitted;
    ir = int'(w.ir_distance);
    sonar = int'(w.sonar_distance);
    obj = '0;
    emitted = 1'b0;
    if (w.sweep_start) begin
      clear_tracking();
    end
    diff = (ir > sonar) ? ir - sonar : sonar - ir;
    hit = (ir > int'(limits.ir_low_limit)) && (ir < int'(limits.ir_high_limit)) &&
          (diff < int'(limits.agree_limit));
    if (hit) begin
      if (hit_run != 8'd255) begin
        hit_run++;
      end
      if (hit_run > limits.confirm_count && !armed) begin
        run_deg = (run_deg > 8'd253) ? 8'd255 : run_deg + 8'd2;
        armed = 1'b1;
        held_distance = w.sonar_distance;
      end
      if (armed) begin
        if (run_deg != 8'd255) begin
          run_deg++;
        end
        tracking = 1'b1;
      end
    end
    if (tracking && (ir < int'(limits.ir_low_limit) || ir > int'(limits.ir_high_limit)) &&
        diff > int'(limits.agree_limit)) begin
      h = int'(run_deg);
      if (h > 180) begin
        h = 360 - h;
      end
      half = int'(run_deg) >> 1;
      width = (int'(held_distance) * half_angle_sine(h) + 2048) >> 12;
      obj.object_number = closed_count;
      obj.object_distance = held_distance;
      obj.object_width = width[12:0];
      obj.object_center = (int'(sweep_angle) >= half) ? 8'(int'(sweep_angle) - half) : 8'd0;
      emitted = 1'b1;
      tracking = 1'b0;
      run_deg = '0;
      hit_run = '0;
      armed = 1'b0;
      closed_count++;
    end
    if (sweep_angle != 8'd255) begin
      sweep_angle++;
    end
    return emitted;
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.ir_distance = 8'($urandom_range(0, 255));
    w.sonar_distance = 10'($urandom_range(0, 1023));
    w.sweep_start = 1'b0;
    return w;
  endfunction

  function automatic in_word_t hit_word();
    in_word_t w;
    int lo;
    int hi;
    int ag;
    int ir;
    int off;
    lo = int'(limits.ir_low_limit);
    hi = int'(limits.ir_high_limit);
    ag = int'(limits.agree_limit);
    if (hi < lo + 2 || ag == 0) begin
      return noise_word();
    end
    ir = $urandom_range(lo + 1, hi - 1);
    off = $urandom_range(0, ag - 1);
    w.ir_distance = 8'(ir);
    w.sonar_distance = 10'(($urandom_range(0, 1) == 1 || ir < off) ? ir + off : ir - off);
    w.sweep_start = 1'b0;
    return w;
  endfunction

  function automatic in_word_t close_word();
    in_word_t w;
    int lo;
    int hi;
    int ag;
    int ir;
    lo = int'(limits.ir_low_limit);
    hi = int'(limits.ir_high_limit);
    ag = int'(limits.agree_limit);
    if (lo == 0 && hi == 255) begin
      return noise_word();
    end
    if (lo > 0 && (hi == 255 || $urandom_range(0, 1) == 1)) begin
      ir = $urandom_range(0, lo - 1);
    end else begin
      ir = $urandom_range(hi + 1, 255);
    end
    w.ir_distance = 8'(ir);
    if (ir > ag + 1 && $urandom_range(0, 1) == 1) begin
      w.sonar_distance = 10'(ir - ag - 1 - $urandom_range(0, ir - ag - 1));
    end else begin
      w.sonar_distance = 10'(ir + ag + 1 + $urandom_range(0, 300));
    end
    w.sweep_start = 1'b0;
    return w;
  endfunction

  function automatic cfg_t random_limits();
    cfg_t c;
    int lo;
    int hi;
    lo = $urandom_range(0, 120);
    hi = $urandom_range(lo + 2, 255);
    if (lo == 0 && hi == 255) begin
      hi = 254;
    end
    c.ir_low_limit = 8'(lo);
    c.ir_high_limit = 8'(hi);
    c.agree_limit = 8'($urandom_range(1, 255));
    c.confirm_count = 4'($urandom_range(0, 15));
    return c;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegIrLow:   limits.ir_low_limit = value;
      RegIrHigh:  limits.ir_high_limit = value;
      RegAgree:   limits.agree_limit = value;
      RegConfirm: limits.confirm_count = value[3:0];
      default: ;
    endcase
  endtask

  task automatic program_limits(cfg_t c);
    write_reg(RegIrLow, c.ir_low_limit);
    write_reg(RegIrHigh, c.ir_high_limit);
    write_reg(RegAgree, c.agree_limit);
    write_reg(RegConfirm, 8'(c.confirm_count));
  endtask

  task automatic push_word(in_word_t w, row_kind_e kind, out_word_t typed_obj);
    out_word_t obj;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    words_sent++;
    if (track_sample(w, obj) && kind == ByModel) begin
      expected_objects.push_back(obj);
    end
    if (kind == TypedObject) begin
      expected_objects.push_back(typed_obj);
    end
  endtask

  task automatic offer(in_word_t w);
    w.sweep_start = sweep_pending;
    sweep_pending = 1'b0;
    push_word(w, ByModel, '0);
  endtask

  task automatic run_sweeps(int budget);
    int target;
    int segs;
    int run;
    target = words_sent + budget;
    while (words_sent < target) begin
      sweep_pending = ($urandom_range(0, 3) != 0);
      segs = $urandom_range(1, 12);
      for (int s = 0; s < segs; s++) begin
        repeat ($urandom_range(0, 4)) offer(noise_word());
        run = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 270) :
              $urandom_range(0, int'(limits.confirm_count) + 8);
        repeat (run) offer(hit_word());
        if ($urandom_range(0, 7) != 0) begin
          offer(close_word());
        end
      end
    end
  endtask

  // one hit and one close per object; with confirm 0 the object count wraps
  task automatic dense_sweep(int objects);
    sweep_pending = 1'b1;
    repeat (objects) begin
      offer(hit_word());
      offer(close_word());
    end
  endtask

  task automatic close_phase();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_objects.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_objects.size() == 0) begin
        $error("object_number: expected none, got %0d", out_word_o.object_number);
        mismatches++;
      end else begin
        want = expected_objects.pop_front();
        compare_field("object_number", want.object_number, out_word_o.object_number);
        compare_field("object_distance", want.object_distance, out_word_o.object_distance);
        compare_field("object_width", want.object_width, out_word_o.object_width);
        compare_field("object_center", want.object_center, out_word_o.object_center);
      end
    end
  end

  // receiver: stall stretches of random density, one long hold-off on request
  initial begin
    int pct;
    forever begin
      if (hold_request && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      case ($urandom_range(0, 2))
        0:       pct = 0;
        1:       pct = 25;
        default: pct = 60;
      endcase
      repeat ($urandom_range(10, 80)) begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    in_word_t w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (ProbeRows[i]) begin
      w.ir_distance = ProbeRows[i].ir;
      w.sonar_distance = ProbeRows[i].sonar;
      w.sweep_start = ProbeRows[i].start;
      push_word(w, ProbeRows[i].kind, ProbeRows[i].obj);
    end
    run_sweeps(120);
    close_phase();

    program_limits('{8'd0, 8'd255, 8'd255, 4'd0});
    run_sweeps(30);
    close_phase();

    // empty window; only objects carried over can close
    program_limits('{8'd255, 8'd0, 8'd0, 4'd15});
    run_sweeps(30);
    close_phase();

    program_limits('{8'd20, 8'd200, 8'd40, 4'd0});
    hold_request = 1'b1;
    dense_sweep(130);
    run_sweeps(80);
    close_phase();

    program_limits('{8'd5, 8'd60, 8'd8, 4'd15});
    run_sweeps(120);
    close_phase();

    repeat (4) begin
      program_limits(random_limits());
      run_sweeps(70);
      close_phase();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
